### rtl/nnis_pkg.sv
// Shared types, register indexes and helper functions of the nearest-neighbor scaler.
`default_nettype none
package nnis_pkg;

   localparam int SIZE_W      = 9;
   localparam int BPP_W       = 3;
   localparam int COORD_W     = 8;
   localparam int PIXEL_W     = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 9;
   localparam int PROD_W      = COORD_W + SIZE_W;
   // quotient is below the source size, so it fits in SIZE_W bits
   localparam int DIV_STEPS   = SIZE_W;
   localparam int STEP_CNT_W  = 4;

   typedef logic [SIZE_W-1:0]      size_type;
   typedef logic [BPP_W-1:0]       bpp_type;
   typedef logic [COORD_W-1:0]     coord_type;
   typedef logic [PIXEL_W-1:0]     pixel_type;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   typedef logic [CSR_DATA_W-1:0]  csr_data_type;

   localparam csr_index_type CSR_SRC_WIDTH  = 3'd0;
   localparam csr_index_type CSR_SRC_HEIGHT = 3'd1;
   localparam csr_index_type CSR_DST_WIDTH  = 3'd2;
   localparam csr_index_type CSR_DST_HEIGHT = 3'd3;
   localparam csr_index_type CSR_BPP        = 3'd4;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   localparam size_type SIZE_ONE = size_type'(1);
   localparam bpp_type  BPP_ONE  = bpp_type'(1);

   // zero acts as one, anything above the limit acts as the limit
   function automatic size_type clamp_size(input size_type v, input size_type max_v);
      size_type r;
      if (v == '0) begin
         r = SIZE_ONE;
      end else if (v > max_v) begin
         r = max_v;
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic pixel_type pixel_mask(input bpp_type bpp);
      pixel_type m;
      case (bpp)
         3'd0, 3'd1: m = 32'h0000_00FF;
         3'd2:       m = 32'h0000_FFFF;
         3'd3:       m = 32'h00FF_FFFF;
         default:    m = 32'hFFFF_FFFF;
      endcase
      return m;
   endfunction

endpackage
`default_nettype wire

### rtl/nnis_if.sv
// Request, response and register-write channel interfaces of the scaler.
`default_nettype none
interface nnis_req_if;
   import nnis_pkg::*;
   logic      valid;
   logic      ready;
   logic      cmd;
   coord_type coord_x;
   coord_type coord_y;
   pixel_type pixel_in;
   modport source (output valid, output cmd, output coord_x, output coord_y,
                   output pixel_in, input ready);
   modport sink   (input valid, input cmd, input coord_x, input coord_y,
                   input pixel_in, output ready);
endinterface

interface nnis_rsp_if;
   import nnis_pkg::*;
   logic      valid;
   logic      ready;
   pixel_type pixel_out;
   logic      out_of_range;
   modport source (output valid, output pixel_out, output out_of_range, input ready);
   modport sink   (input valid, input pixel_out, input out_of_range, output ready);
endinterface

interface nnis_csr_if;
   import nnis_pkg::*;
   logic          valid;
   logic          ready;
   csr_index_type index;
   csr_data_type  data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### rtl/nearest_neighbor_image_scaler.sv
// Top level: nearest-neighbor scaler with frame store, coordinate dividers and result register.
`default_nettype none
// After a write the block stays idle, so a new item is accepted in the next cycle.
// In-range reads go through the accept/multiply, the row and column restoring-divider steps
//   (separate dividers, run side by side), a frame-store read and the result load.
// Out-of-range reads go straight to the result load. A read blocks new requests until it loads.
// Reset (synchronous, active high) clears control state and sets all size
//   registers and bytes-per-pixel to 1; the frame store is not cleared.
module nearest_neighbor_image_scaler #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input wire logic   clock,
   input wire logic   reset,
   nnis_req_if.sink   req_bus,
   nnis_rsp_if.source rsp_bus,
   nnis_csr_if.sink   csr_bus
);
   import nnis_pkg::*;

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SIZE_MAX_VAL = (1 << SIZE_W) - 1;
   // largest effective size per axis, limited by the register width
   localparam size_type LIMIT_W =
      size_type'((MAX_WIDTH  > SIZE_MAX_VAL) ? SIZE_MAX_VAL : MAX_WIDTH);
   localparam size_type LIMIT_H =
      size_type'((MAX_HEIGHT > SIZE_MAX_VAL) ? SIZE_MAX_VAL : MAX_HEIGHT);

   // sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DIV  = 3'd1;
   localparam logic [2:0] S_RD   = 3'd2;
   localparam logic [2:0] S_DONE = 3'd3;

   // configuration registers, raw as written
   size_type src_w_ff, src_h_ff, dst_w_ff, dst_h_ff;
   bpp_type  bpp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff <= SIZE_ONE;
         src_h_ff <= SIZE_ONE;
         dst_w_ff <= SIZE_ONE;
         dst_h_ff <= SIZE_ONE;
         bpp_ff   <= BPP_ONE;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_SRC_WIDTH:  src_w_ff <= csr_bus.data;
            CSR_SRC_HEIGHT: src_h_ff <= csr_bus.data;
            CSR_DST_WIDTH:  dst_w_ff <= csr_bus.data;
            CSR_DST_HEIGHT: dst_h_ff <= csr_bus.data;
            CSR_BPP:        bpp_ff   <= csr_bus.data[BPP_W-1:0];
            default: ;      // unmapped index, dropped
         endcase
      end
   end

   assign csr_bus.ready = 1'b1;

   // effective sizes; user must keep config static while an item is in flight; unchecked
   size_type sw, sh, dw, dh;
   assign sw = clamp_size(src_w_ff, LIMIT_W);
   assign sh = clamp_size(src_h_ff, LIMIT_H);
   assign dw = clamp_size(dst_w_ff, LIMIT_W);
   assign dh = clamp_size(dst_h_ff, LIMIT_H);

   logic [2:0]            state_ff, state_in;
   logic [STEP_CNT_W-1:0] step_ff, step_in;
   // divider: remainder and a dividend/quotient shift register per axis
   size_type              rem_x_ff, rem_x_in, rem_y_ff, rem_y_in;
   size_type              quo_x_ff, quo_x_in, quo_y_ff, quo_y_in;
   logic                  oor_ff, oor_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   pixel_type             rsp_pixel_ff, rsp_pixel_in;
   logic                  rsp_oor_ff, rsp_oor_in;

   logic                  req_xfer, is_read, wr_hit, rd_oor, rsp_load, rsp_free;
   logic [PROD_W-1:0]     prod_x, prod_y;
   logic [SIZE_W:0]       trial_x, trial_y;
   logic                  ge_x, ge_y;

   logic                  ram_we;
   logic [AW-1:0]         ram_addr, wr_addr, rd_addr;
   pixel_type             ram_wdata, ram_rdata;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_xfer      = req_bus.valid && req_bus.ready;
   assign is_read       = (req_bus.cmd == CMD_READ);

   // writes outside the source image are dropped
   assign wr_hit = ({1'b0, req_bus.coord_x} < sw) && ({1'b0, req_bus.coord_y} < sh);
   assign rd_oor = ({1'b0, req_bus.coord_x} >= dw) || ({1'b0, req_bus.coord_y} >= dh);

   // scaled numerators, one multiply each in the accept cycle
   assign prod_x = PROD_W'(req_bus.coord_x) * PROD_W'(sw);
   assign prod_y = PROD_W'(req_bus.coord_y) * PROD_W'(sh);

   // restoring division step: quotient < 2^SIZE_W, so numerator[top] < divisor
   assign trial_x = {rem_x_ff, quo_x_ff[SIZE_W-1]};
   assign trial_y = {rem_y_ff, quo_y_ff[SIZE_W-1]};
   assign ge_x    = trial_x >= {1'b0, dw};
   assign ge_y    = trial_y >= {1'b0, dh};

   assign rsp_free = !rsp_valid_ff || rsp_bus.ready;
   assign rsp_load = (state_ff == S_DONE) && rsp_free;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      rem_x_in = rem_x_ff;
      rem_y_in = rem_y_ff;
      quo_x_in = quo_x_ff;
      quo_y_in = quo_y_ff;
      oor_in   = oor_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_xfer && is_read) begin
               oor_in   = rd_oor;
               step_in  = '0;
               rem_x_in = size_type'(prod_x[PROD_W-1:SIZE_W]);
               rem_y_in = size_type'(prod_y[PROD_W-1:SIZE_W]);
               quo_x_in = prod_x[SIZE_W-1:0];
               quo_y_in = prod_y[SIZE_W-1:0];
               state_in = rd_oor ? S_DONE : S_DIV;
            end
         end
         S_DIV: begin
            rem_x_in = ge_x ? SIZE_W'(trial_x - {1'b0, dw}) : trial_x[SIZE_W-1:0];
            rem_y_in = ge_y ? SIZE_W'(trial_y - {1'b0, dh}) : trial_y[SIZE_W-1:0];
            quo_x_in = {quo_x_ff[SIZE_W-2:0], ge_x};
            quo_y_in = {quo_y_ff[SIZE_W-2:0], ge_y};
            step_in  = step_ff + 1'b1;
            if (step_ff == STEP_CNT_W'(DIV_STEPS - 1)) begin
               state_in = S_RD;
            end
         end
         S_RD: begin
            state_in = S_DONE;   // read address is on the store this cycle
         end
         S_DONE: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // result register: lets the next write/read enter while a result waits
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_pixel_in = rsp_pixel_ff;
      rsp_oor_in   = rsp_oor_ff;
      if (rsp_bus.valid && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_oor_in   = oor_ff;
         rsp_pixel_in = oor_ff ? '0 : ram_rdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff      <= step_in;
      rem_x_ff     <= rem_x_in;
      rem_y_ff     <= rem_y_in;
      quo_x_ff     <= quo_x_in;
      quo_y_ff     <= quo_y_in;
      oor_ff       <= oor_in;
      rsp_pixel_ff <= rsp_pixel_in;
      rsp_oor_ff   <= rsp_oor_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.pixel_out    = rsp_pixel_ff;
   assign rsp_bus.out_of_range = rsp_oor_ff;

   // frame store, row-major with a row pitch of MAX_WIDTH words;
   // writes only happen in idle, reads hold their address until the result loads
   assign wr_addr = AW'(AW'(req_bus.coord_y) * AW'(MAX_WIDTH)) + AW'(req_bus.coord_x);
   assign rd_addr = AW'(AW'(quo_y_ff) * AW'(MAX_WIDTH)) + AW'(quo_x_ff);

   assign ram_we    = req_xfer && !is_read && wr_hit;
   assign ram_addr  = (state_ff == S_IDLE) ? wr_addr : rd_addr;
   assign ram_wdata = req_bus.pixel_in & pixel_mask(bpp_ff);

   nnis_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (DEPTH)
   ) u_frame_store (
      .clock   (clock),
      .we      (ram_we),
      .addr    (ram_addr),
      .wr_data (ram_wdata),
      .rd_data (ram_rdata)
   );

   // an out-of-range result always carries a zero pixel
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_oor_ff |-> rsp_pixel_ff == '0)
      else $error("out-of-range result with nonzero pixel");

   // the store is only written while no read is in flight
   assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !ram_we)
      else $error("frame store write during a read");

   // the divider never runs past its step count
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> step_ff < STEP_CNT_W'(DIV_STEPS))
      else $error("divider step count overrun");

   // the scaled coordinate lands inside the source image
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RD |-> (quo_x_ff < sw) && (quo_y_ff < sh))
      else $error("scaled coordinate outside source image");

   // a waiting result is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> !rsp_valid_ff || rsp_bus.ready)
      else $error("result register overwritten");

endmodule
`default_nettype wire

### rtl/nnis_ram.sv
// Generic single-port synchronous RAM with registered read data.
`default_nettype none
module nnis_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    addr,
   input  wire logic [WIDTH-1:0] wr_data,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### test/testbench.sv
// Self-checking testbench for the nearest-neighbor image scaler.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import nnis_pkg::*;

   localparam int FRAME_W        = 256;
   localparam int FRAME_H        = 256;
   localparam int ITEM_TARGET    = 1850;
   localparam int PHASE_ITEMS    = 150;
   // quiet cycles between the last transfer and a register change
   localparam int SETTLE_CYCLES  = 16;
   localparam int WATCHDOG_LIMIT = 4000;

   typedef struct packed {
      logic      cmd;
      coord_type coord_x;
      coord_type coord_y;
      pixel_type pixel_in;
   } request_type;

   typedef struct packed {
      pixel_type pixel;
      logic      off_image;
   } reply_type;

   logic clock;
   logic reset;

   nnis_req_if req_bus ();
   nnis_rsp_if rsp_bus ();
   nnis_csr_if csr_bus ();

   nearest_neighbor_image_scaler DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // ---------------------------------------------------------------------------
   // Shared state
   // ---------------------------------------------------------------------------

   // stimulus side: what is queued and which source pixels have been stored
   request_type req_pending[$];
   request_type req_head;
   bit        written [0:FRAME_W*FRAME_H-1];
   int        plan_sw = 1, plan_sh = 1, plan_dw = 1, plan_dh = 1;
   int        items_queued = 0;
   int        stim_count   = 0;
   int        settings_count = 0;
   bit        no_idle = 1'b0;

   // prediction side: own copy of the registers and of the frame store
   size_type  size_regs [0:3];
   bpp_type   bpp_reg;
   pixel_type frame_model [0:FRAME_W*FRAME_H-1];
   reply_type expected_pixels[$];

   int        req_accepted = 0;
   bit        req_taken = 1'b0;
   int        idle_cycles = 0;
   int        req_gap = 0;
   int        rsp_stall = 0;
   int        fault_count = 0;
   int        n_writes = 0, n_reads = 0, n_off_image = 0, n_checked = 0;

   // ---------------------------------------------------------------------------
   // Helpers
   // ---------------------------------------------------------------------------

   // zero behaves as one, anything past the frame limit as the limit
   function automatic int eff_size(input size_type v, input int limit);
      if (v == '0) return 1;
      if (int'(v) > limit) return limit;
      return int'(v);
   endfunction

   function automatic pixel_type byte_mask(input bpp_type b);
      int nbytes;
      nbytes = (b == '0) ? 1 : ((int'(b) > 4) ? 4 : int'(b));
      if (nbytes == 4) return '1;
      return (pixel_type'(1) << (8 * nbytes)) - pixel_type'(1);
   endfunction

   // mostly back-to-back, some short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic pixel_type rand_pixel();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return pixel_type'($urandom);
   endfunction

   // small images dominate; zero and oversize values exercise the clamping
   function automatic size_type pick_size();
      int r;
      r = $urandom_range(0, 9);
      case (r)
         0:       return '0;
         1:       return size_type'(256);
         2:       return size_type'($urandom_range(257, 511));
         3, 4:    return size_type'($urandom_range(1, 256));
         default: return size_type'($urandom_range(1, 20));
      endcase
   endfunction

   function automatic void note_fault(input string msg);
      fault_count++;
      if (fault_count <= 10) $display("MISMATCH: %s", msg);
   endfunction

   // ---------------------------------------------------------------------------
   // Predictor: updates the frame store copy, queues the pixel a read returns
   // ---------------------------------------------------------------------------
   task automatic scale_request(input request_type r);
      int        sw, sh, dw, dh, sx, sy;
      reply_type e;
      sw = eff_size(size_regs[CSR_SRC_WIDTH], FRAME_W);
      sh = eff_size(size_regs[CSR_SRC_HEIGHT], FRAME_H);
      dw = eff_size(size_regs[CSR_DST_WIDTH], FRAME_W);
      dh = eff_size(size_regs[CSR_DST_HEIGHT], FRAME_H);
      if (r.cmd == CMD_WRITE) begin
         // writes past the source image are dropped silently
         if (r.coord_x < sw && r.coord_y < sh) begin
            frame_model[int'(r.coord_y) * FRAME_W + int'(r.coord_x)] =
               r.pixel_in & byte_mask(bpp_reg);
            n_writes++;
         end
      end else begin
         n_reads++;
         if (r.coord_x >= dw || r.coord_y >= dh) begin
            e.pixel     = '0;
            e.off_image = 1'b1;
            n_off_image++;
         end else begin
            sx = (int'(r.coord_x) * sw) / dw;
            sy = (int'(r.coord_y) * sh) / dh;
            e.pixel     = frame_model[sy * FRAME_W + sx];
            e.off_image = 1'b0;
         end
         expected_pixels.push_back(e);
      end
   endtask

   // ---------------------------------------------------------------------------
   // Stimulus planning
   // ---------------------------------------------------------------------------
   task automatic add_write(input coord_type x, input coord_type y, input pixel_type pix);
      request_type r;
      r = '{CMD_WRITE, x, y, pix};
      req_pending.push_back(r);
      items_queued++;
      if (x < plan_sw && y < plan_sh) begin
         written[int'(y) * FRAME_W + int'(x)] = 1'b1;
         stim_count++;
      end
   endtask

   // an in-range read whose source pixel was never stored gets a write first
   task automatic add_read(input coord_type x, input coord_type y);
      int          sx, sy;
      request_type r;
      if (x < plan_dw && y < plan_dh) begin
         sx = (int'(x) * plan_sw) / plan_dw;
         sy = (int'(y) * plan_sh) / plan_dh;
         if (!written[sy * FRAME_W + sx])
            add_write(coord_type'(sx), coord_type'(sy), rand_pixel());
      end
      r = '{CMD_READ, x, y, pixel_type'($urandom)};
      req_pending.push_back(r);
      items_queued++;
      stim_count++;
   endtask

   // wait until every queued transfer went in and every read came back
   task automatic drain();
      do @(negedge clock);
      while (req_accepted != items_queued || expected_pixels.size() != 0);
   endtask

   task automatic write_reg(input csr_index_type idx, input csr_data_type val);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= val;
      do @(posedge clock);
      while (!(csr_bus.valid && csr_bus.ready));
   endtask

   task automatic configure(input size_type sw, input size_type sh, input size_type dw,
                            input size_type dh, input bpp_type bpp);
      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      write_reg(CSR_SRC_WIDTH, sw);
      write_reg(CSR_SRC_HEIGHT, sh);
      write_reg(CSR_DST_WIDTH, dw);
      write_reg(CSR_DST_HEIGHT, dh);
      write_reg(CSR_BPP, csr_data_type'(bpp));
      @(negedge clock);
      csr_bus.valid <= 1'b0;
      plan_sw = eff_size(sw, FRAME_W);
      plan_sh = eff_size(sh, FRAME_H);
      plan_dw = eff_size(dw, FRAME_W);
      plan_dh = eff_size(dh, FRAME_H);
      settings_count++;
   endtask

   // ---------------------------------------------------------------------------
   // Clock
   // ---------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // Request driver: one transfer per handshake, random gaps between them
   // ---------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_gap       <= 0;
      end else if (!req_bus.valid || req_taken) begin
         if (req_gap > 0) begin
            req_bus.valid <= 1'b0;
            req_gap       <= req_gap - 1;
         end else if (req_pending.size() != 0) begin
            req_head = req_pending.pop_front();
            req_bus.valid    <= 1'b1;
            req_bus.cmd      <= req_head.cmd;
            req_bus.coord_x  <= req_head.coord_x;
            req_bus.coord_y  <= req_head.coord_y;
            req_bus.pixel_in <= req_head.pixel_in;
            req_gap          <= pick_gap();
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Response back-pressure: ready drops for random stretches
   // ---------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall     <= 0;
      end else if (rsp_stall > 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall     <= rsp_stall - 1;
      end else begin
         rsp_bus.ready <= 1'b1;
         if ($urandom_range(0, 5) == 0) rsp_stall <= pick_gap();
      end
   end

   // ---------------------------------------------------------------------------
   // Monitor: tracks register writes, predicts on request transfers,
   // checks response transfers against the oldest expectation
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      reply_type want;
      if (reset) begin
         req_taken   <= 1'b0;
         idle_cycles <= 0;
         foreach (size_regs[i]) size_regs[i] = SIZE_ONE;
         bpp_reg = BPP_ONE;
      end else begin
         req_taken <= req_bus.valid && req_bus.ready;

         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               CSR_SRC_WIDTH:  size_regs[CSR_SRC_WIDTH]  = csr_bus.data;
               CSR_SRC_HEIGHT: size_regs[CSR_SRC_HEIGHT] = csr_bus.data;
               CSR_DST_WIDTH:  size_regs[CSR_DST_WIDTH]  = csr_bus.data;
               CSR_DST_HEIGHT: size_regs[CSR_DST_HEIGHT] = csr_bus.data;
               CSR_BPP:        bpp_reg = bpp_type'(csr_bus.data);
               default: ;
            endcase
         end

         if (req_bus.valid && req_bus.ready) begin
            scale_request(request_type'{req_bus.cmd, req_bus.coord_x, req_bus.coord_y,
                                        req_bus.pixel_in});
            req_accepted <= req_accepted + 1;
         end

         if (rsp_bus.valid && rsp_bus.ready) begin
            n_checked++;
            if (expected_pixels.size() == 0) begin
               note_fault($sformatf("unexpected result pixel=%h off_image=%b",
                                    rsp_bus.pixel_out, rsp_bus.out_of_range));
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_bus.pixel_out !== want.pixel)
                  note_fault($sformatf("pixel_out expected %h actual %h",
                                       want.pixel, rsp_bus.pixel_out));
               if (rsp_bus.out_of_range !== want.off_image)
                  note_fault($sformatf("out_of_range expected %b actual %b",
                                       want.off_image, rsp_bus.out_of_range));
            end
         end

         // any transfer on any channel counts as progress
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (csr_bus.valid && csr_bus.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------------
   // Watchdog: too long without any transfer means the block is stuck
   // ---------------------------------------------------------------------------
   initial begin
      do @(negedge clock);
      while (idle_cycles < WATCHDOG_LIMIT);
      $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------
   initial begin
      int phase;
      int n;
      int r;
      coord_type x, y;

      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.cmd      = CMD_WRITE;
      req_bus.coord_x  = '0;
      req_bus.coord_y  = '0;
      req_bus.pixel_in = '0;
      rsp_bus.ready    = 1'b0;
      csr_bus.valid    = 1'b0;
      csr_bus.index    = CSR_SRC_WIDTH;
      csr_bus.data     = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // --- directed part ---
      // reset values: 1x1 images, one byte per pixel
      add_write(8'd0, 8'd0, 32'hDEAD_BEEF);
      add_read(8'd0, 8'd0);
      add_read(8'd1, 8'd0);

      // full-size images, all four bytes, corner coordinates
      configure(9'd256, 9'd256, 9'd256, 9'd256, 3'd4);
      add_write(8'd0, 8'd0, 32'hFFFF_FFFF);
      add_write(8'd255, 8'd255, 32'h0000_0000);
      add_write(8'd255, 8'd0, 32'hA5A5_A5A5);
      add_write(8'd0, 8'd255, 32'h5A5A_5A5A);
      add_read(8'd0, 8'd0);
      add_read(8'd255, 8'd255);
      add_read(8'd255, 8'd0);
      add_read(8'd0, 8'd255);

      // zero source size acts as one, oversize destination acts as the maximum;
      // writes past the 1x1 source are dropped
      configure(9'd0, 9'd0, 9'd511, 9'd300, 3'd1);
      add_write(8'd0, 8'd0, 32'h1234_5678);
      add_write(8'd1, 8'd0, 32'h8765_4321);
      add_write(8'd0, 8'd1, 32'hFFFF_FFFF);
      add_read(8'd255, 8'd255);
      add_read(8'd0, 8'd0);

      // strong downscale to 4x2, zero bytes per pixel acts as one;
      // reads past the destination come back flagged
      configure(9'd256, 9'd256, 9'd4, 9'd2, 3'd0);
      add_read(8'd4, 8'd0);
      add_read(8'd0, 8'd2);
      add_read(8'd255, 8'd255);
      add_write(8'd192, 8'd128, 32'hCAFE_F00D);
      add_read(8'd3, 8'd1);
      add_read(8'd1, 8'd0);

      // --- random part: one register setting per phase ---
      phase = 0;
      while (stim_count < ITEM_TARGET) begin
         configure(pick_size(), pick_size(), pick_size(), pick_size(),
                   bpp_type'($urandom_range(0, 7)));
         // every fourth phase runs without gaps or stalls
         no_idle = (phase % 4 == 3);
         for (n = 0; n < PHASE_ITEMS && stim_count < ITEM_TARGET; n++) begin
            r = $urandom_range(0, 99);
            if (r < 20) begin
               // mostly inside the source image, some dropped writes
               if ($urandom_range(0, 9) != 0) begin
                  x = coord_type'($urandom_range(0, plan_sw - 1));
                  y = coord_type'($urandom_range(0, plan_sh - 1));
               end else begin
                  x = coord_type'($urandom_range(0, 255));
                  y = coord_type'($urandom_range(0, 255));
               end
               add_write(x, y, rand_pixel());
            end else if (r < 28) begin
               add_read(coord_type'($urandom_range(0, 255)),
                        coord_type'($urandom_range(0, 255)));
            end else begin
               add_read(coord_type'($urandom_range(0, plan_dw - 1)),
                        coord_type'($urandom_range(0, plan_dh - 1)));
            end
         end
         phase++;
      end

      drain();
      no_idle = 1'b0;
      repeat (20) @(negedge clock);

      $display("Covered %0d stored pixels and %0d scaled reads (%0d past the destination)",
               n_writes, n_reads, n_off_image);
      $display("over %0d register settings; %0d results checked, %0d mismatches",
               settings_count, n_checked, fault_count);
      if (fault_count == 0 && expected_pixels.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/nnis_pkg.sv
rtl/nnis_if.sv
rtl/nnis_ram.sv
rtl/nearest_neighbor_image_scaler.sv
test/testbench.sv
